// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HECM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HECM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hecm_pkg.sv =====
// Types and constants for the histogram-equalised colour map.
package hecm_pkg;

    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_COLOR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_BLUE    = 3'd5;

    localparam logic [CHAN_W-1:0] RST_START_RED   = 8'd0;
    localparam logic [CHAN_W-1:0] RST_START_GREEN = 8'd0;
    localparam logic [CHAN_W-1:0] RST_START_BLUE  = 8'd0;
    localparam logic [CHAN_W-1:0] RST_END_RED     = 8'd0;
    localparam logic [CHAN_W-1:0] RST_END_GREEN   = 8'd255;
    localparam logic [CHAN_W-1:0] RST_END_BLUE    = 8'd0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [10:0] iteration_count;
    } hecm_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } hecm_out_t;

    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] level;
    } hecm_blend_stat_t;

endpackage

// ===== rtl/hecm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hecm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hecm_blend.sv =====
// One colour channel of the gradient: two products, a sum, then an 8-step divide.
module hecm_blend import hecm_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [CHAN_W-1:0]     start_level,
    input  logic [CHAN_W-1:0]     end_level,
    input  logic [COUNT_BITS-1:0] cum,
    input  logic [COUNT_BITS-1:0] total,
    output hecm_blend_stat_t      stat
);

    localparam int NW     = COUNT_BITS + CHAN_W;
    localparam int STEP_W = $clog2(CHAN_W);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_SUM  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;

    logic [1:0]            phase_reg, phase_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [NW-1:0]         p0_reg, p0_next;
    logic [NW-1:0]         p1_reg, p1_next;
    logic [NW-1:0]         rem_reg, rem_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [CHAN_W-1:0]     q_reg, q_next;
    logic                  done_reg, done_next;

    logic [NW-1:0] dshift;
    logic          fits;

    // trial subtrahend: total scaled to the quotient bit under test
    assign dshift = NW'(total_reg) << step_reg;
    assign fits   = (rem_reg >= dshift);

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        case (phase_reg)
            P_IDLE:
            begin
                if (go)
                begin
                    // cum never exceeds total, so the difference stays unsigned
                    p0_next    = NW'(start_level) * NW'(total - cum);
                    p1_next    = NW'(end_level) * NW'(cum);
                    total_next = total;
                    phase_next = P_SUM;
                end
            end
            P_SUM:
            begin
                rem_next   = p0_reg + p1_reg;
                step_next  = STEP_W'(CHAN_W - 1);
                q_next     = '0;
                phase_next = P_DIV;
            end
            P_DIV:
            begin
                rem_next = fits ? (rem_reg - dshift) : rem_reg;
                q_next   = {q_reg[CHAN_W-2:0], fits};
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        rem_reg   <= rem_next;
        total_reg <= total_next;
        q_reg     <= q_next;
    end

    assign stat.done  = done_reg;
    assign stat.level = q_reg;

endmodule

// ===== rtl/histogram_equalized_color_map.sv =====
// Histogram-equalised colour map for escape-time iteration counts.
// A request is taken when start is high and busy is low; a colour request
// gives one result on result, flagged by done for a single cycle, and the
// receiver has no way to hold it off, so it must take it then. After reset,
// and after each clear request, the histogram RAM is swept to zero with
// busy high. A count request below MAX_ITER keeps busy high through a
// read, then a saturating write-back of one RAM entry. A colour
// request for a count at or above MAX_ITER, or with an empty total, answers
// in the next cycle. Any other colour request first makes one histogram
// RAM read per cycle to sum bins 0..count, then passes the three channels
// one after another through a shared unit (product, sum, 8-step restoring
// divide). Configuration writes may be made at any time the block is idle
// and take effect at once.
module histogram_equalized_color_map import hecm_pkg::*; #(
    parameter int MAX_ITER   = 1024,
    parameter int COUNT_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hecm_in_t              item,
    output logic                  busy,
    output logic                  done,
    output hecm_out_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
    localparam logic [AW-1:0]         LAST_ADDR = AW'(MAX_ITER - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_CNT_RD = 3'd2;
    localparam logic [2:0] S_CNT_WR = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_BGO    = 3'd5;
    localparam logic [2:0] S_BWAIT  = 3'd6;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : (v + COUNT_ONE);
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [AW-1:0]         lim_reg, lim_next;
    logic                  issued_reg, issued_next;
    logic                  rvld_reg, rvld_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [1:0]            ch_reg, ch_next;
    hecm_out_t             result_reg, result_next;
    logic                  done_reg, done_next;

    logic [CHAN_W-1:0] start_red_reg, start_green_reg, start_blue_reg;
    logic [CHAN_W-1:0] end_red_reg, end_green_reg, end_blue_reg;

    logic                  accept;
    logic                  in_range;
    logic                  ram_we;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS:0]   acc_sum;
    logic                  blend_go;
    logic [CHAN_W-1:0]     blend_start, blend_end;
    hecm_blend_stat_t      blend_stat;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(item.iteration_count) < 32'(MAX_ITER));
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, ram_rdata};

    always_comb
    begin
        case (ch_reg)
            CH_RED:
            begin
                blend_start = start_red_reg;
                blend_end   = end_red_reg;
            end
            CH_GREEN:
            begin
                blend_start = start_green_reg;
                blend_end   = end_green_reg;
            end
            default:
            begin
                blend_start = start_blue_reg;
                blend_end   = end_blue_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        lim_next    = lim_reg;
        issued_next = issued_reg;
        rvld_next   = 1'b0;
        acc_next    = acc_reg;
        total_next  = total_reg;
        ch_next     = ch_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        blend_go    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.operation)
                        OP_CLEAR:
                        begin
                            addr_next  = '0;
                            total_next = '0;
                            state_next = S_SWEEP;
                        end
                        OP_COUNT:
                        begin
                            if (in_range)
                            begin
                                addr_next  = AW'(item.iteration_count);
                                state_next = S_CNT_RD;
                            end
                        end
                        OP_COLOR:
                        begin
                            if (!in_range)
                            begin
                                result_next = '0;
                                done_next   = 1'b1;
                            end
                            else if (total_reg == '0)
                            begin
                                result_next.red   = start_red_reg;
                                result_next.green = start_green_reg;
                                result_next.blue  = start_blue_reg;
                                done_next         = 1'b1;
                            end
                            else
                            begin
                                addr_next   = '0;
                                lim_next    = AW'(item.iteration_count);
                                issued_next = 1'b0;
                                acc_next    = '0;
                                state_next  = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                ram_we = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_CNT_RD:
            begin
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = sat_inc(ram_rdata);
                total_next = sat_inc(total_reg);
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (!issued_reg)
                begin
                    rvld_next = 1'b1;
                    if (addr_reg == lim_reg)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                // running sum held at the total, as saturated bins may overshoot
                if (rvld_reg)
                begin
                    acc_next = (acc_sum > {1'b0, total_reg}) ? total_reg
                                                             : acc_sum[COUNT_BITS-1:0];
                end
                if (issued_reg && !rvld_reg)
                begin
                    ch_next    = CH_RED;
                    state_next = S_BGO;
                end
            end
            S_BGO:
            begin
                blend_go   = 1'b1;
                state_next = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (blend_stat.done)
                begin
                    case (ch_reg)
                        CH_RED:   result_next.red   = blend_stat.level;
                        CH_GREEN: result_next.green = blend_stat.level;
                        default:  result_next.blue  = blend_stat.level;
                    endcase
                    if (ch_reg == CH_BLUE)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_BGO;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            addr_reg   <= '0;
            issued_reg <= 1'b0;
            rvld_reg   <= 1'b0;
            total_reg  <= '0;
            ch_reg     <= CH_RED;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            issued_reg <= issued_next;
            rvld_reg   <= rvld_next;
            total_reg  <= total_next;
            ch_reg     <= ch_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg    <= lim_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_red_reg   <= RST_START_RED;
            start_green_reg <= RST_START_GREEN;
            start_blue_reg  <= RST_START_BLUE;
            end_red_reg     <= RST_END_RED;
            end_green_reg   <= RST_END_GREEN;
            end_blue_reg    <= RST_END_BLUE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_RED:   start_red_reg   <= cfg_data;
                REG_START_GREEN: start_green_reg <= cfg_data;
                REG_START_BLUE:  start_blue_reg  <= cfg_data;
                REG_END_RED:     end_red_reg     <= cfg_data;
                REG_END_GREEN:   end_green_reg   <= cfg_data;
                REG_END_BLUE:    end_blue_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    hecm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_ITER)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    hecm_blend #(
        .COUNT_BITS (COUNT_BITS)
    ) u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (blend_go),
        .start_level (blend_start),
        .end_level   (blend_end),
        .cum         (acc_reg),
        .total       (total_reg),
        .stat        (blend_stat)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/hecm_chk.sv =====
// Port-level checks for the colour map, bound to the top level.
`include "assert_macros.svh"

module hecm_chk import hecm_pkg::*; #(
    parameter int MAX_ITER = 1024
) (
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input hecm_in_t  item,
    input logic      busy,
    input logic      done,
    input hecm_out_t result
);

    // a result follows either a colour transfer or a stretch of work
    `HECM_ASSERT_IMP(a_done_source, done, $past(busy) || ($past(start) && ($past(item.operation) == OP_COLOR)), "result without a colour request")

    // clear and count transfers never produce a result
    `HECM_ASSERT_NXT(a_no_result, start && !busy && (item.operation != OP_COLOR), !done, "result after clear or count")

    // a clear always starts the sweep
    `HECM_ASSERT_NXT(a_clear_busy, start && !busy && (item.operation == OP_CLEAR), busy, "clear did not start sweep")

    // a pixel inside the set is black, next cycle
    `HECM_ASSERT_NXT(a_inside_black, start && !busy && (item.operation == OP_COLOR) && (32'(item.iteration_count) >= 32'(MAX_ITER)), done && (result == '0), "inside-set pixel not black")

endmodule

bind histogram_equalized_color_map hecm_chk #(
    .MAX_ITER (MAX_ITER)
) u_hecm_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);
